### rtl/core/nsi_pkg.sv
// Package for the number string to integer converter.
// Holds payload types, ASCII character codes and the hex digit limit.
// No dependencies.
`default_nettype none

package nsi_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [63:0] value_t;
	typedef logic [7:0]  count_t;

	// hex digits allowed after the 0x prefix (0..16)
	localparam int MAX_HEX_DIGITS = 16;

	localparam count_t COUNT_MAX = 8'hFF;

	localparam char_t CHAR_NUL   = 8'h00;
	localparam char_t CHAR_0     = 8'h30;
	localparam char_t CHAR_9     = 8'h39;
	localparam char_t CHAR_MINUS = 8'h2D;
	localparam char_t CHAR_X_LO  = 8'h78;
	localparam char_t CHAR_X_UP  = 8'h58;
	localparam char_t CHAR_A_LO  = 8'h61;
	localparam char_t CHAR_F_LO  = 8'h66;
	localparam char_t CHAR_A_UP  = 8'h41;
	localparam char_t CHAR_F_UP  = 8'h46;

endpackage

`default_nettype wire

### rtl/core/nsi_if.sv
// Valid/ready channel interfaces: character input and parsed result output.
// Depends on nsi_pkg.
`default_nettype none

interface nsi_char_if;
	import nsi_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface nsi_result_if;
	import nsi_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	count_t char_count;
	logic   is_hex;
	logic   status;

	modport source (output valid, output value, output char_count, output is_hex,
		output status, input ready);
	modport sink   (input valid, input value, input char_count, input is_hex,
		input status, output ready);
endinterface

`default_nettype wire

### rtl/core/number_string_to_integer_top.sv
// Top level of the ASCII hex/decimal string to 64-bit integer converter.
// Depends on nsi_pkg and the channel interfaces in nsi_if.sv.
//
//   channel  | dir | payload                                | transfer
//   ---------+-----+----------------------------------------+-----------------------------
//   chars    | in  | char_code[7:0]                         | one character, 0 = end
//   results  | out | value[63:0], char_count[7:0], is_hex,  | one per terminator
//            |     | status                                 |
//
// Cycles: one character per clock, sustained unless a terminator waits (see Stalls).
//   A character is latched in the input register, then the parse state and (on a
//   terminator) the result register update from it; the result is presented from
//   the result register, which follows the input register.
// Stalls: a terminator waits in the input register only while the result
//   register still holds an untaken result, and input is held off behind it;
//   other characters never wait on the output.
// Reset: arst_n clears the input/result valid flags and the parse state
//   (start of string, accumulator zero, no sign, no error).
`default_nettype none

module number_string_to_integer_top (
	input  wire               clk,
	input  wire               arst_n,
	nsi_char_if.sink          chars,
	nsi_result_if.source      results
);
	import nsi_pkg::*;

	// parse phases
	localparam logic [1:0] PH_START = 2'd0;   // nothing taken yet
	localparam logic [1:0] PH_ZERO  = 2'd1;   // lone leading '0' seen
	localparam logic [1:0] PH_DEC   = 2'd2;
	localparam logic [1:0] PH_HEX   = 2'd3;

	// input register
	logic  valid_s1;
	char_t char_s1;

	// parse state
	logic [1:0] phase_q, phase_d;
	value_t     acc_q, acc_d;
	count_t     count_q, count_d;
	logic       neg_q, neg_d;
	logic       err_q, err_d;

	// result register
	logic   out_valid_q;
	value_t out_value_q;
	count_t out_count_q;
	logic   out_hex_q;
	logic   out_status_q;

	logic   is_term;
	logic   advance;
	logic   is_dig;
	logic   is_hex_lo;
	logic   is_hex_up;
	logic   is_x;
	logic [3:0] hex_val;
	value_t acc_x10;
	value_t acc_x16;
	count_t count_inc;
	value_t res_value;

	assign is_term = (char_s1 == CHAR_NUL);

	// terminator needs a free (or emptying) result register
	assign advance = valid_s1 && (!is_term || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	// character classes
	always_comb begin
		is_dig    = char_s1 inside {[CHAR_0:CHAR_9]};
		is_hex_lo = char_s1 inside {[CHAR_A_LO:CHAR_F_LO]};
		is_hex_up = char_s1 inside {[CHAR_A_UP:CHAR_F_UP]};
		is_x      = (char_s1 == CHAR_X_LO) || (char_s1 == CHAR_X_UP);
	end

	// '0'..'9' carry their value in the low nibble; 'a'/'A' low nibble is 1
	assign hex_val = is_dig ? char_s1[3:0] : char_s1[3:0] + 4'd9;

	// acc * 10 + digit as shift-and-add
	assign acc_x10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0}
		+ {60'd0, char_s1[3:0]};
	assign acc_x16 = {acc_q[59:0], hex_val};
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		count_d = count_q;
		neg_d   = neg_q;
		err_d   = err_q;
		if (advance) begin
			if (is_term) begin
				phase_d = PH_START;
				acc_d   = '0;
				count_d = '0;
				neg_d   = 1'b0;
				err_d   = 1'b0;
			end else if (!err_q) begin
				case (phase_q)
					PH_START: begin
						if (char_s1 == CHAR_0) begin
							count_d = 8'd1;
							phase_d = PH_ZERO;
						end else if (char_s1 == CHAR_MINUS) begin
							neg_d   = 1'b1;
							count_d = 8'd1;
							phase_d = PH_DEC;
						end else if (is_dig) begin
							acc_d   = acc_x10;
							count_d = count_inc;
							phase_d = PH_DEC;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_ZERO: begin
						if (is_x) begin
							acc_d   = '0;
							count_d = '0;
							phase_d = PH_HEX;
						end else if (is_dig) begin
							acc_d   = acc_x10;
							count_d = count_inc;
							phase_d = PH_DEC;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_DEC: begin
						if (is_dig) begin
							acc_d   = acc_x10;
							count_d = count_inc;
						end else begin
							err_d = 1'b1;
						end
					end
					PH_HEX: begin
						if (!(is_dig || is_hex_lo || is_hex_up)) begin
							err_d = 1'b1;
						end else if (count_q >= 8'(MAX_HEX_DIGITS)) begin
							err_d = 1'b1;   // digit past the limit
						end else begin
							acc_d   = acc_x16;
							count_d = count_inc;
						end
					end
					default: begin
						phase_d = PH_START;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			count_q <= '0;
			neg_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			count_q <= count_d;
			neg_q   <= neg_d;
			err_q   <= err_d;
		end
	end

	// negative decimals leave as two's complement
	always_comb begin
		if (err_q) begin
			res_value = '0;
		end else if (phase_q != PH_HEX && neg_q) begin
			res_value = 64'd0 - acc_q;
		end else begin
			res_value = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_term) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term) begin
			out_value_q  <= res_value;
			out_count_q  <= err_q ? 8'd0 : count_q;
			out_hex_q    <= (phase_q == PH_HEX);
			out_status_q <= err_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.value      = out_value_q;
	assign results.char_count = out_count_q;
	assign results.is_hex     = out_hex_q;
	assign results.status     = out_status_q;

endmodule

`default_nettype wire

### rtl/core/nsi_checker.sv
// Port-level checks for number_string_to_integer_top, attached by bind.
// Depends on nsi_pkg.
`default_nettype none

module nsi_checker (
	input wire              clk,
	input wire              arst_n,
	input wire              in_ready,
	input wire              out_valid,
	input wire              out_ready,
	input wire [63:0]       out_value,
	input wire [7:0]        out_char_count,
	input wire              out_is_hex,
	input wire              out_status
);
	import nsi_pkg::*;

	// a pending result stays up until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// errors report zero value and zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status |-> out_value == 64'd0 && out_char_count == 8'd0)
		else $error("error result carries nonzero value or count");

	// hex digit count never passes the limit
	a_hex_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_hex |-> out_char_count <= 8'(MAX_HEX_DIGITS))
		else $error("hex count above limit");

	// input is only held off by a pending result
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

bind number_string_to_integer_top nsi_checker u_nsi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (chars.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_value      (results.value),
	.out_char_count (results.char_count),
	.out_is_hex     (results.is_hex),
	.out_status     (results.status)
);

`default_nettype wire

### test/tb_number_string_to_integer_top.sv
// Testbench for number_string_to_integer_top: ASCII strings in, parsed 64-bit numbers out.
// Self-checking against an in-bench parser, with random idling on both channels.
// Depends on nsi_pkg, nsi_if.sv and the RTL top.
`timescale 1ns / 1ps

module tb_number_string_to_integer_top;
	import nsi_pkg::*;

	// One result transfer, in the order of the result channel fields.
	typedef struct packed {
		value_t value;
		count_t char_count;
		logic   is_hex;
		logic   status;
	} parsed_number_t;

	// Where the parser stands within the current string.
	typedef enum logic [1:0] {
		AT_START,
		AFTER_ZERO,
		IN_DECIMAL,
		IN_HEX
	} parse_phase_e;

	// Directed string: sent as-is plus a terminator. Where typed is set, want is the
	// number the terminator must produce; otherwise the parser decides.
	typedef struct {
		string          text;
		bit             typed;
		parsed_number_t want;
	} directed_row_t;

	localparam int ITEM_TARGET  = 2000;
	localparam int QUIET_LIMIT  = 2000; // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 8;    // settling time before the final verdict

	logic clk;
	logic arst_n;

	nsi_char_if   chars_if ();
	nsi_result_if results_if ();

	number_string_to_integer_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	// Parser state, mirrors the block's string state.
	parse_phase_e parse_phase;
	value_t       parse_acc;
	count_t       parse_cnt;
	logic         parse_neg;
	logic         parse_err;

	parsed_number_t parsed_backlog [$]; // numbers owed by the block, oldest first
	int             bad_numbers   = 0;
	int             chars_counted = 0;  // characters sent, terminators included
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             quiet_cycles  = 0;

	// Short special cases first; typed-in numbers are the obvious ones.
	directed_row_t directed_rows [] = '{
		'{"",     1'b1, '{64'd0, 8'd0, 1'b0, 1'b0}},                  // empty string
		'{"-",    1'b1, '{64'd0, 8'd1, 1'b0, 1'b0}},                  // lone sign
		'{"0",    1'b1, '{64'd0, 8'd1, 1'b0, 1'b0}},                  // lone zero
		'{"0x",   1'b1, '{64'd0, 8'd0, 1'b1, 1'b0}},                  // empty hex
		'{"-7",   1'b1, '{64'hFFFF_FFFF_FFFF_FFF9, 8'd2, 1'b0, 1'b0}},
		'{"0XfA", 1'b1, '{64'h0000_0000_0000_00FA, 8'd2, 1'b1, 1'b0}},
		'{"1-",   1'b1, '{64'd0, 8'd0, 1'b0, 1'b1}},                  // sign not first
		'{"0xg",  1'b1, '{64'd0, 8'd0, 1'b1, 1'b1}},                  // bad hex digit
		'{"09",   1'b0, '0}                                           // leading zero
	};

	// Value extremes, wrap, and the hex digit limit.
	string extreme_texts [] = '{
		"18446744073709551615",
		"18446744073709551616",
		"-9223372036854775808",
		"-0",
		"0xFFFFFFFFFFFFFFFF",
		"0xffffffffffffffff0"
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- parser

	function automatic void clear_parse();
		parse_phase = AT_START;
		parse_acc   = '0;
		parse_cnt   = '0;
		parse_neg   = 1'b0;
		parse_err   = 1'b0;
	endfunction

	function automatic void bump_count();
		if (parse_cnt != COUNT_MAX) begin
			parse_cnt = parse_cnt + 8'd1;
		end
	endfunction

	// decimal digit: wraps modulo 2^64
	function automatic void take_decimal(input char_t c);
		parse_acc   = parse_acc * 64'd10 + value_t'(c - CHAR_0);
		parse_phase = IN_DECIMAL;
		bump_count();
	endfunction

	// Feeds one character; returns 1 when it closes a string, with the number in num.
	function automatic bit parse_char(input char_t c, output parsed_number_t num);
		logic [3:0] digit;
		bit         is_digit;
		bit         is_hex_digit;
		num      = '0;
		is_digit = (c >= CHAR_0) && (c <= CHAR_9);
		if (c == CHAR_NUL) begin
			num.is_hex = (parse_phase == IN_HEX);
			num.status = parse_err;
			if (!parse_err) begin
				num.value      = (parse_phase != IN_HEX && parse_neg) ?
					value_t'(0) - parse_acc : parse_acc;
				num.char_count = parse_cnt;
			end
			clear_parse();
			return 1'b1;
		end
		// after an error the rest of the string is dropped
		if (parse_err) begin
			return 1'b0;
		end
		case (parse_phase)
			AT_START: begin
				if (c == CHAR_0) begin
					parse_cnt   = 8'd1;
					parse_phase = AFTER_ZERO;
				end else if (c == CHAR_MINUS) begin
					parse_neg   = 1'b1;
					parse_cnt   = 8'd1;
					parse_phase = IN_DECIMAL;
				end else if (is_digit) begin
					take_decimal(c);
				end else begin
					parse_err = 1'b1;
				end
			end
			AFTER_ZERO: begin
				if (c == CHAR_X_LO || c == CHAR_X_UP) begin
					parse_acc   = '0;
					parse_cnt   = '0;
					parse_phase = IN_HEX;
				end else if (is_digit) begin
					take_decimal(c);
				end else begin
					parse_err = 1'b1;
				end
			end
			IN_DECIMAL: begin
				if (is_digit) begin
					take_decimal(c);
				end else begin
					parse_err = 1'b1;
				end
			end
			default: begin
				is_hex_digit = 1'b1;
				digit        = '0;
				if (is_digit) begin
					digit = 4'(c - CHAR_0);
				end else if (c >= CHAR_A_LO && c <= CHAR_F_LO) begin
					digit = 4'(c - CHAR_A_LO + 8'd10);
				end else if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
					digit = 4'(c - CHAR_A_UP + 8'd10);
				end else begin
					is_hex_digit = 1'b0;
				end
				// a digit past the limit is an error, like a bad character
				if (!is_hex_digit || parse_cnt >= MAX_HEX_DIGITS) begin
					parse_err = 1'b1;
				end else begin
					parse_acc = {parse_acc[59:0], digit};
					bump_count();
				end
			end
		endcase
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- char side

	// One character transfer. Gaps are random; char_code carries junk while valid is low.
	// The parser runs on the edge that takes the character.
	task automatic send_char(input char_t c, input bit typed, input parsed_number_t want);
		parsed_number_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			chars_if.valid     <= 1'b0;
			chars_if.char_code <= char_t'($urandom);
			@(negedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready) begin
			@(posedge clk);
		end
		chars_counted++;
		if (parse_char(c, predicted)) begin
			parsed_backlog.push_back(typed ? want : predicted);
		end
	endtask

	// Whole string plus terminator; only the terminator carries a typed number.
	task automatic send_string(input char_t text [$], input bit typed,
		input parsed_number_t want);
		foreach (text[i]) begin
			send_char(text[i], 1'b0, '0);
		end
		send_char(CHAR_NUL, typed, want);
	endtask

	// Sender holds off until every owed number has been taken.
	task automatic hold_until_drained();
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (parsed_backlog.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic char_t hex_char(input int unsigned d);
		if (d < 10) begin
			return CHAR_0 + char_t'(d);
		end
		return ($urandom_range(1) ? CHAR_A_UP : CHAR_A_LO) + char_t'(d - 10);
	endfunction

	function automatic void push_text(ref char_t text [$], input string s);
		for (int i = 0; i < s.len(); i++) begin
			text.push_back(char_t'(s[i]));
		end
	endfunction

	// Mostly well-formed strings with random content; the rest broken or noise.
	task automatic build_random_string(ref char_t text [$]);
		int kind;
		int len;
		text = {};
		kind = $urandom_range(99);
		if (kind < 30) begin
			// decimal, now and then long enough to wrap
			if ($urandom_range(3) == 0) begin
				text.push_back(CHAR_MINUS);
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 8);
			repeat (len) text.push_back(CHAR_0 + char_t'($urandom_range(9)));
		end else if (kind < 62) begin
			// hex, often right at or one past the digit limit
			text.push_back(CHAR_0);
			text.push_back($urandom_range(1) ? CHAR_X_UP : CHAR_X_LO);
			case ($urandom_range(3))
				0: len = MAX_HEX_DIGITS;
				1: len = MAX_HEX_DIGITS + 1;
				default: len = $urandom_range(0, MAX_HEX_DIGITS);
			endcase
			repeat (len) text.push_back(hex_char($urandom_range(15)));
		end else if (kind < 80) begin
			// good start, then a stray byte and trailing junk
			if ($urandom_range(1)) begin
				text.push_back(CHAR_0);
				text.push_back(CHAR_X_LO);
				repeat ($urandom_range(4)) text.push_back(hex_char($urandom_range(15)));
			end else begin
				if ($urandom_range(1)) begin
					text.push_back(CHAR_MINUS);
				end
				repeat ($urandom_range(4)) text.push_back(CHAR_0 + char_t'($urandom_range(9)));
			end
			text.push_back(char_t'($urandom_range(1, 255)));
			repeat ($urandom_range(3)) text.push_back(char_t'($urandom_range(1, 255)));
		end else if (kind < 90) begin
			repeat ($urandom_range(5)) text.push_back(char_t'($urandom_range(1, 255)));
		end else if (kind < 98) begin
			push_text(text, extreme_texts[$urandom_range(extreme_texts.size() - 1)]);
		end else begin
			// long decimal around the point where the count saturates
			repeat ($urandom_range(250, 262)) text.push_back(CHAR_0 + char_t'($urandom_range(9)));
		end
	endtask

	// ---------------------------------------------------------------- result side

	// Receiver stalls at random; ready only moves on the falling edge.
	always @(negedge clk) begin
		results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_number();
		parsed_number_t got;
		parsed_number_t want;
		got = '{results_if.value, results_if.char_count, results_if.is_hex, results_if.status};
		if (parsed_backlog.size() == 0) begin
			$display("%0t: result with none owed: value=%h count=%0d hex=%b status=%b",
				$time, got.value, got.char_count, got.is_hex, got.status);
			bad_numbers++;
			return;
		end
		want = parsed_backlog.pop_front();
		if (got.value !== want.value) begin
			$display("%0t: value expected %h got %h", $time, want.value, got.value);
			bad_numbers++;
		end
		if (got.char_count !== want.char_count) begin
			$display("%0t: char_count expected %0d got %0d", $time, want.char_count,
				got.char_count);
			bad_numbers++;
		end
		if (got.is_hex !== want.is_hex) begin
			$display("%0t: is_hex expected %b got %b", $time, want.is_hex, got.is_hex);
			bad_numbers++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %b got %b", $time, want.status, got.status);
			bad_numbers++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready) begin
			check_number();
		end
	end

	// Watchdog: too long with no transfer on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
			(results_if.valid && results_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		char_t text [$];
		chars_if.valid     = 1'b0;
		chars_if.char_code = CHAR_NUL;
		arst_n             = 1'b0;
		clear_parse();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// three idling regimes: slow receiver, slow sender, then full rate
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (regime == 0) begin
				foreach (directed_rows[r]) begin
					text = {};
					push_text(text, directed_rows[r].text);
					send_string(text, directed_rows[r].typed, directed_rows[r].want);
				end
				// extremes once each, checked by the parser
				foreach (extreme_texts[e]) begin
					text = {};
					push_text(text, extreme_texts[e]);
					send_string(text, 1'b0, '0);
				end
			end
			while (chars_counted < (regime + 1) * ITEM_TARGET / 3) begin
				build_random_string(text);
				send_string(text, 1'b0, '0);
			end
			// let the output side run dry between regimes
			hold_until_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_numbers == 0 && parsed_backlog.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
